@@ hdl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared widths and beat types for the least common multiple unit.
// ----------------------------------------------------------------------------
package lcm_pkg;

    // Width of the operand and result fields on the ports.
    localparam int DATA_W = 64;

    // Arithmetic width: only the low WIDTH bits of each operand are used.
    localparam int WIDTH = 64;

    // Step counter width for the bit-serial units (counts WIDTH-1 down to 0).
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // Input beat: two unsigned operands.
    typedef struct packed {
        logic [DATA_W-1:0] first_value;
        logic [DATA_W-1:0] second_value;
    } lcm_in_t;

    // Output beat: the multiple and the overflow flag.
    typedef struct packed {
        logic [DATA_W-1:0] multiple;
        logic              overflow;
    } lcm_out_t;

endpackage

@@ hdl/lcm_divider.sv @@
// ----------------------------------------------------------------------------
// lcm_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcm_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [lcm_pkg::WIDTH-1:0] dividend,
    input  logic [lcm_pkg::WIDTH-1:0] divisor,
    output logic                     done,
    output logic [lcm_pkg::WIDTH-1:0] quotient,
    output logic [lcm_pkg::WIDTH-1:0] remainder
);
    import lcm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // One trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/lcm_multiplier.sv @@
// ----------------------------------------------------------------------------
// lcm_multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lcm_multiplier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lcm_pkg::WIDTH-1:0]   multiplicand,
    input  logic [lcm_pkg::WIDTH-1:0]   multiplier,
    output logic                       done,
    output logic [2*lcm_pkg::WIDTH-1:0] product
);
    import lcm_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WIDTH-1:0]   mcd_reg, mcd_next;
    logic [WIDTH-1:0]   mlr_reg, mlr_next;
    logic [2*WIDTH-1:0] acc_reg, acc_next;

    logic [WIDTH:0]     sum;

    // Add the multiplicand into the upper half when the current bit is set.
    assign sum = {1'b0, acc_reg[2*WIDTH-1:WIDTH]}
               + {1'b0, (mlr_reg[0] ? mcd_reg : {WIDTH{1'b0}})};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mcd_next  = mcd_reg;
        mlr_next  = mlr_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            mcd_next  = multiplicand;
            mlr_next  = multiplier;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[WIDTH-1:1]};
            mlr_next = {1'b0, mlr_reg[WIDTH-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mcd_reg <= mcd_next;
        mlr_reg <= mlr_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ hdl/lcm_euclid_unit.sv @@
// ----------------------------------------------------------------------------
// lcm_euclid_unit
// Least common multiple of two unsigned operands by Euclid's remainder loop.
// ----------------------------------------------------------------------------
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_ready, in_data    | in
//   output  | out_valid, out_ready, out_data | out
//
// Each beat runs the remainder steps of Euclid's loop on the shared
// bit-serial divider, then one division for the quotient and one
// multiplication. A zero operand skips straight to the result.
// Reset clears the sequencer and both units; there is no clearing pass.
// The input is ready only while idle; a finished result waits in its own
// register when the output stalls, and the next beat may enter meanwhile.
// ----------------------------------------------------------------------------
module lcm_euclid_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lcm_pkg::lcm_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lcm_pkg::lcm_out_t out_data
);
    import lcm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_QUOT = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic             go_reg, go_next;
    logic             out_valid_reg, out_valid_next;
    lcm_out_t         out_data_reg, out_data_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] big_reg, big_next;
    logic [WIDTH-1:0] small_reg, small_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic             ovf_reg, ovf_next;

    logic [WIDTH-1:0]   in_a;
    logic [WIDTH-1:0]   in_b;
    logic               div_start;
    logic               div_done;
    logic [WIDTH-1:0]   div_dividend;
    logic [WIDTH-1:0]   div_quo;
    logic [WIDTH-1:0]   div_rem;
    logic               mul_start;
    logic               mul_done;
    logic [2*WIDTH-1:0] mul_prod;

    // Only the low WIDTH bits of each operand take part.
    assign in_a = in_data.first_value[WIDTH-1:0];
    assign in_b = in_data.second_value[WIDTH-1:0];

    // The divider serves both the remainder loop and the final quotient.
    assign div_start    = go_reg && ((state_reg == S_GCD) || (state_reg == S_QUOT));
    assign div_dividend = (state_reg == S_QUOT) ? a_reg : big_reg;
    assign mul_start    = go_reg && (state_reg == S_MUL);

    lcm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (small_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    lcm_multiplier u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (q_reg),
        .multiplier   (b_reg),
        .done         (mul_done),
        .product      (mul_prod)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        big_next       = big_reg;
        small_next     = small_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        ovf_next       = ovf_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = in_a;
                    b_next = in_b;
                    if (in_a == '0)
                    begin
                        res_next   = in_b;
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (in_b == '0)
                    begin
                        res_next   = in_a;
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        big_next   = in_a;
                        small_next = in_b;
                        go_next    = 1'b1;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (div_done)
                begin
                    go_next = 1'b1;
                    if (div_rem == '0)
                    begin
                        state_next = S_QUOT;
                    end
                    else
                    begin
                        big_next   = small_reg;
                        small_next = div_rem;
                    end
                end
            end
            S_QUOT:
            begin
                if (div_done)
                begin
                    q_next     = div_quo;
                    go_next    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    res_next   = mul_prod[WIDTH-1:0];
                    ovf_next   = |mul_prod[2*WIDTH-1:WIDTH];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.multiple = DATA_W'(res_reg);
                    out_data_next.overflow = ovf_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        big_reg      <= big_next;
        small_reg    <= small_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        ovf_reg      <= ovf_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The two arithmetic units never finish in the same cycle.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_done && mul_done))
        else $error("divider and multiplier finished together");

    // A division result only arrives while the sequencer waits for one.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_GCD) || (state_reg == S_QUOT)))
        else $error("divider finished outside a division state");

    // A product only arrives while the sequencer waits for it.
    a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiplier finished outside the multiply state");

    // The divisor is never zero while a division is in flight.
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_GCD) || (state_reg == S_QUOT)) |-> (small_reg != '0))
        else $error("zero divisor in the remainder loop");

endmodule

@@ bench/tb_lcm_euclid_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcm_euclid_unit
// Self-checking bench for the least common multiple unit. Operand pairs are
// sent through the input channel. Each accepted beat is scored against an
// in-bench least common multiple calculation with an overflow check. Both
// channels stall at random, and a quiet stretch closes the run.
// ----------------------------------------------------------------------------
module tb_lcm_euclid_unit;

    import lcm_pkg::*;

    // Worst case is about 95 remainder steps per beat, plus stalls on both sides,
    // for roughly 750 beats. The limit is several times that.
    localparam int CYCLE_LIMIT  = 30_000_000;
    localparam int DRAIN_CYCLES = 400;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FIB_92   = 64'd7540113804746346429;
    localparam logic [63:0] FIB_93   = 64'd12200160415121876738;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    lcm_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lcm_out_t out_data;

    // Multiples still owed by the block, oldest first.
    lcm_out_t pending_multiples[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       ready_hold     = 0;
    bit       calm_phase     = 1'b0;

    lcm_euclid_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mask that keeps the low w bits of a 64-bit word, for w from 1 to 64.
    function automatic logic [63:0] low_bits_mask(input int w);
        return ALL_ONES >> (64 - w);
    endfunction

    // Least common multiple of the low WIDTH bits of both operands, with the
    // overflow flag set when the full product does not fit in WIDTH bits.
    function automatic lcm_out_t predict_lcm(input lcm_in_t beat);
        logic [63:0]  keep;
        logic [63:0]  op_a;
        logic [63:0]  op_b;
        logic [63:0]  divisor;
        logic [63:0]  dividend;
        logic [63:0]  remainder;
        logic [127:0] product;
        lcm_out_t     res;
        keep = low_bits_mask(WIDTH);
        op_a = 64'(beat.first_value) & keep;
        op_b = 64'(beat.second_value) & keep;
        res  = '0;
        if (op_a == 64'd0)
        begin
            res.multiple = DATA_W'(op_b);
        end
        else if (op_b == 64'd0)
        begin
            res.multiple = DATA_W'(op_a);
        end
        else
        begin
            // Euclid's remainder loop on the smaller and larger operand.
            divisor  = (op_a < op_b) ? op_a : op_b;
            dividend = (op_a < op_b) ? op_b : op_a;
            remainder = dividend % divisor;
            while (remainder != 64'd0)
            begin
                dividend  = divisor;
                divisor   = remainder;
                remainder = dividend % divisor;
            end
            product      = {64'd0, op_a / divisor} * {64'd0, op_b};
            res.multiple = DATA_W'(product[63:0] & keep);
            res.overflow = ((product >> WIDTH) != 128'd0);
        end
        return res;
    endfunction

    // Send one operand pair. Called at a falling edge; returns at the falling
    // edge after the beat is taken, with valid still high.
    task automatic send_operands(input logic [63:0] first, input logic [63:0] second);
        lcm_in_t beat;
        beat.first_value  = DATA_W'(first);
        beat.second_value = DATA_W'(second);
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Output stall pattern: stall bursts between ready runs, with an occasional
    // long run of steady ready. The closing stretch
    // keeps ready high at once, even in the middle of a stall burst.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (calm_phase)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 15);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(100, 400);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 31);
        end
    end

    // Record the expected multiple for each accepted input beat, and score
    // each accepted output beat against the oldest one.
    always @(posedge clk)
    begin
        lcm_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_multiples.push_back(predict_lcm(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (pending_multiples.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual multiple %h overflow %b",
                             $time, out_data.multiple, out_data.overflow);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_multiples.pop_front();
                    if (out_data.multiple !== want.multiple)
                    begin
                        $display("%0t: multiple mismatch, expected %h, actual %h",
                                 $time, want.multiple, out_data.multiple);
                        mismatch_count++;
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow mismatch, expected %b, actual %b",
                                 $time, want.overflow, out_data.overflow);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // A zero operand passes the other one through, both zero gives zero.
    task automatic test_zero_operands();
        send_operands(64'd0, 64'd0);
        send_operands(64'd0, ALL_ONES);
        send_operands(ALL_ONES, 64'd0);
        send_operands(64'd0, 64'd1);
        send_operands(64'd1, 64'd0);
    endtask

    // Ones and all-ones operands at the edges of the field range.
    task automatic test_operand_extremes();
        send_operands(64'd1, 64'd1);
        send_operands(ALL_ONES, ALL_ONES);
        send_operands(64'd1, ALL_ONES);
        send_operands(ALL_ONES, 64'd1);
        send_operands(ALL_ONES, ALL_ONES - 64'd1);
    endtask

    // Shared factors, equal operands, and the longest remainder chain
    // (consecutive Fibonacci numbers).
    task automatic test_common_factors();
        send_operands(64'd12, 64'd18);
        send_operands(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'd6, 64'd6);
        send_operands(FIB_92, FIB_93);
    endtask

    // Products just past and just inside the result width.
    task automatic test_product_overflow();
        send_operands(64'h1_0000_0000, 64'h1_0000_0001);
        send_operands(64'hFFFF_FFFF, 64'h1_0000_0001);
        send_operands(64'h8000_0000_0000_0000, 64'd3);
        send_operands(ALL_ONES, 64'd2);
    endtask

    // Random operand pairs: full-width words, small values, pairs with a
    // shared factor, pairs where one divides the other, zero operands, and
    // operands of random bit lengths.
    task automatic test_random_mix(input int count);
        logic [63:0] op_a;
        logic [63:0] op_b;
        logic [63:0] factor;
        logic [63:0] swap;
        for (int i = 0; i < count; i++)
        begin
            op_a = {$urandom, $urandom};
            op_b = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                end
                3, 4:
                begin
                    op_a &= low_bits_mask($urandom_range(1, 16));
                    op_b &= low_bits_mask($urandom_range(1, 16));
                end
                5, 6:
                begin
                    factor = {$urandom, $urandom} >> $urandom_range(24, 63);
                    op_a   = factor * 64'($urandom_range(1, 1 << 20));
                    op_b   = factor * 64'($urandom_range(1, 1 << 20));
                end
                7:
                begin
                    op_a = 64'($urandom);
                    op_b = op_a * 64'($urandom_range(1, 65535));
                end
                8:
                begin
                    op_a = 64'd0;
                end
                default:
                begin
                    op_a &= low_bits_mask($urandom_range(1, 64));
                    op_b &= low_bits_mask($urandom_range(1, 64));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                swap = op_a;
                op_a = op_b;
                op_b = swap;
            end
            send_operands(op_a, op_b);
        end
    endtask

    // Closing stretch with both sides always ready.
    task automatic test_back_to_back(input int count);
        calm_phase = 1'b1;
        test_random_mix(count);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_operands();
        test_operand_extremes();
        test_common_factors();
        test_product_overflow();
        test_random_mix(680);
        test_back_to_back(50);

        in_valid <= 1'b0;
        while (pending_multiples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_multiples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
